// ===== rtl/tlik_pkg.sv =====
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared types, command codes and constants for the two-link IK unit.
// ----------------------------------------------------------------------------
package tlik_pkg;

  // CORDIC iterations for both the vectoring and the rotation pass.
  localparam int CORDIC_STEPS = 16;

  // Angles are signed Q4.16 radians, trig results Q16.
  localparam logic signed [20:0] ANG_PI      = 21'sd205887;
  localparam logic signed [20:0] ANG_HALF_PI = 21'sd102944;
  localparam logic signed [35:0] CORDIC_INV_GAIN = 36'sd39797;

  // Configuration register indexes.
  localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [2:0] REG_FIRST_LENGTH  = 3'd2;
  localparam logic [2:0] REG_SECOND_LENGTH = 3'd3;
  localparam logic [2:0] REG_MIRROR_ELBOW  = 3'd4;

  // Datapath operation codes.
  typedef logic [4:0] op_t;
  localparam op_t OP_NOP   = 5'd0;
  localparam op_t OP_LOAD  = 5'd1;
  localparam op_t OP_M1    = 5'd2;
  localparam op_t OP_M2    = 5'd3;
  localparam op_t OP_SQ0   = 5'd4;
  localparam op_t OP_SQST  = 5'd5;
  localparam op_t OP_DSET  = 5'd6;
  localparam op_t OP_ZERO  = 5'd7;
  localparam op_t OP_VINIT = 5'd8;
  localparam op_t OP_VSTEP = 5'd9;
  localparam op_t OP_RINIT = 5'd10;
  localparam op_t OP_RSTEP = 5'd11;
  localparam op_t OP_RFIN  = 5'd12;
  localparam op_t OP_M3    = 5'd13;
  localparam op_t OP_M4    = 5'd14;
  localparam op_t OP_M5    = 5'd15;
  localparam op_t OP_M6    = 5'd16;
  localparam op_t OP_DEN   = 5'd17;
  localparam op_t OP_CHK   = 5'd18;
  localparam op_t OP_DSTEP = 5'd19;
  localparam op_t OP_DFIN  = 5'd20;
  localparam op_t OP_M7    = 5'd21;
  localparam op_t OP_SQ1   = 5'd22;
  localparam op_t OP_M8    = 5'd23;
  localparam op_t OP_M9    = 5'd24;
  localparam op_t OP_M10   = 5'd25;
  localparam op_t OP_M11   = 5'd26;
  localparam op_t OP_M12   = 5'd27;
  localparam op_t OP_M13   = 5'd28;
  localparam op_t OP_M14   = 5'd29;
  localparam op_t OP_M15   = 5'd30;
  localparam op_t OP_M16   = 5'd31;

  // Command from controller to datapath.
  typedef struct packed {
    op_t        op;
    logic [4:0] idx;
    logic       out_load;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic d_zero;
    logic need_div;
  } stat_t;

  // Arctangent table: round(atan(2^-i) * 65536).
  function automatic logic [15:0] atan_val(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30386;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/two_link_inverse_kinematics_unit.sv =====
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics_unit
// Solves a two-link planar arm for a target point: elbow and reach point.
// ----------------------------------------------------------------------------
// Channel   Handshake                    Payload
// input     in_valid_i / in_ready_o      goal_x_i, goal_y_i
// output    out_valid_o / out_ready_i    elbow_x_o, elbow_y_o, reach_x_o,
//                                        reach_y_o, out_of_reach_o
// config    cfg_we_i                     cfg_idx_i, cfg_data_i
//
// Items are solved one at a time by the sequencer on the shared datapath:
// two 17-step square roots, two 16-step CORDIC passes and a 16-step divide.
// A clamped cosine skips the divide; a zero distance also skips both CORDIC
// passes. Input is ready only when idle; a result waits in the output
// register while the next item is taken, and the last step holds while
// that register is full. Reset loads register defaults and empties the output.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] goal_x_i,
  input  logic signed [15:0] goal_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] elbow_x_o,
  output logic signed [16:0] elbow_y_o,
  output logic signed [17:0] reach_x_o,
  output logic signed [17:0] reach_y_o,
  output logic               out_of_reach_o
);
  import tlik_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  tlik_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Arithmetic datapath.
  tlik_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .goal_x_i       (goal_x_i),
    .goal_y_i       (goal_y_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .elbow_x_o      (elbow_x_o),
    .elbow_y_o      (elbow_y_o),
    .reach_x_o      (reach_x_o),
    .reach_y_o      (reach_y_o),
    .out_of_reach_o (out_of_reach_o)
  );

endmodule

// ===== rtl/tlik_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlik_ctrl
// Sequencer that steps the datapath through one inverse kinematics solve.
// ----------------------------------------------------------------------------
module tlik_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  tlik_pkg::stat_t stat_i,
  output tlik_pkg::cmd_t  cmd_o
);
  import tlik_pkg::*;

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_M1    = 6'd1;
  localparam logic [5:0] S_M2    = 6'd2;
  localparam logic [5:0] S_SQ0   = 6'd3;
  localparam logic [5:0] S_SQA   = 6'd4;
  localparam logic [5:0] S_DSET  = 6'd5;
  localparam logic [5:0] S_ZTST  = 6'd6;
  localparam logic [5:0] S_ZERO  = 6'd7;
  localparam logic [5:0] S_VINIT = 6'd8;
  localparam logic [5:0] S_VSTEP = 6'd9;
  localparam logic [5:0] S_RINIT = 6'd10;
  localparam logic [5:0] S_RSTEP = 6'd11;
  localparam logic [5:0] S_RFIN  = 6'd12;
  localparam logic [5:0] S_M3    = 6'd13;
  localparam logic [5:0] S_M4    = 6'd14;
  localparam logic [5:0] S_M5    = 6'd15;
  localparam logic [5:0] S_M6    = 6'd16;
  localparam logic [5:0] S_DEN   = 6'd17;
  localparam logic [5:0] S_CHK   = 6'd18;
  localparam logic [5:0] S_DSTEP = 6'd19;
  localparam logic [5:0] S_DFIN  = 6'd20;
  localparam logic [5:0] S_M7    = 6'd21;
  localparam logic [5:0] S_SQ1   = 6'd22;
  localparam logic [5:0] S_SQB   = 6'd23;
  localparam logic [5:0] S_M8    = 6'd24;
  localparam logic [5:0] S_M9    = 6'd25;
  localparam logic [5:0] S_M10   = 6'd26;
  localparam logic [5:0] S_M11   = 6'd27;
  localparam logic [5:0] S_M12   = 6'd28;
  localparam logic [5:0] S_M13   = 6'd29;
  localparam logic [5:0] S_M14   = 6'd30;
  localparam logic [5:0] S_M15   = 6'd31;
  localparam logic [5:0] S_M16   = 6'd32;
  localparam logic [5:0] S_FIN   = 6'd33;

  localparam logic [4:0] SQRT_LAST   = 5'd16;
  localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);
  localparam logic [4:0] DIV_LAST    = 5'd15;

  logic [5:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state, step counter and datapath command.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o.op       = OP_NOP;
    cmd_o.idx      = cnt_q;
    cmd_o.out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_M1;
        end
      end
      S_M1:  begin cmd_o.op = OP_M1;  state_d = S_M2; end
      S_M2:  begin cmd_o.op = OP_M2;  state_d = S_SQ0; end
      S_SQ0: begin cmd_o.op = OP_SQ0; state_d = S_SQA; cnt_d = '0; end
      S_SQA: begin
        cmd_o.op = OP_SQST;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == SQRT_LAST) begin
          cnt_d   = '0;
          state_d = S_DSET;
        end
      end
      S_DSET: begin cmd_o.op = OP_DSET; state_d = S_ZTST; end
      S_ZTST: state_d = stat_i.d_zero ? S_ZERO : S_VINIT;
      S_ZERO: begin cmd_o.op = OP_ZERO; state_d = S_M3; end
      S_VINIT: begin cmd_o.op = OP_VINIT; state_d = S_VSTEP; end
      S_VSTEP: begin
        cmd_o.op = OP_VSTEP;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == CORDIC_LAST) begin
          cnt_d   = '0;
          state_d = S_RINIT;
        end
      end
      S_RINIT: begin cmd_o.op = OP_RINIT; state_d = S_RSTEP; end
      S_RSTEP: begin
        cmd_o.op = OP_RSTEP;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == CORDIC_LAST) begin
          cnt_d   = '0;
          state_d = S_RFIN;
        end
      end
      S_RFIN: begin cmd_o.op = OP_RFIN; state_d = S_M3; end
      S_M3:  begin cmd_o.op = OP_M3;  state_d = S_M4; end
      S_M4:  begin cmd_o.op = OP_M4;  state_d = S_M5; end
      S_M5:  begin cmd_o.op = OP_M5;  state_d = S_M6; end
      S_M6:  begin cmd_o.op = OP_M6;  state_d = S_DEN; end
      S_DEN: begin cmd_o.op = OP_DEN; state_d = S_CHK; end
      S_CHK: begin
        cmd_o.op = OP_CHK;
        cnt_d    = '0;
        state_d  = stat_i.need_div ? S_DSTEP : S_M7;
      end
      S_DSTEP: begin
        cmd_o.op = OP_DSTEP;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == DIV_LAST) begin
          cnt_d   = '0;
          state_d = S_DFIN;
        end
      end
      S_DFIN: begin cmd_o.op = OP_DFIN; state_d = S_M7; end
      S_M7:  begin cmd_o.op = OP_M7;  state_d = S_SQ1; end
      S_SQ1: begin cmd_o.op = OP_SQ1; state_d = S_SQB; cnt_d = '0; end
      S_SQB: begin
        cmd_o.op = OP_SQST;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == SQRT_LAST) begin
          cnt_d   = '0;
          state_d = S_M8;
        end
      end
      S_M8:  begin cmd_o.op = OP_M8;  state_d = S_M9; end
      S_M9:  begin cmd_o.op = OP_M9;  state_d = S_M10; end
      S_M10: begin cmd_o.op = OP_M10; state_d = S_M11; end
      S_M11: begin cmd_o.op = OP_M11; state_d = S_M12; end
      S_M12: begin cmd_o.op = OP_M12; state_d = S_M13; end
      S_M13: begin cmd_o.op = OP_M13; state_d = S_M14; end
      S_M14: begin cmd_o.op = OP_M14; state_d = S_M15; end
      S_M15: begin cmd_o.op = OP_M15; state_d = S_M16; end
      S_M16: begin cmd_o.op = OP_M16; state_d = S_FIN; end
      S_FIN: begin
        // Move the result into the output register once it is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/tlik_dp.sv =====
// ----------------------------------------------------------------------------
// tlik_dp
// Datapath: configuration registers, shared multiplier, square root,
// divider and CORDIC registers, and the result registers.
// ----------------------------------------------------------------------------
module tlik_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic signed [15:0]  goal_x_i,
  input  logic signed [15:0]  goal_y_i,
  input  tlik_pkg::cmd_t      cmd_i,
  output tlik_pkg::stat_t     stat_o,
  output logic signed [16:0]  elbow_x_o,
  output logic signed [16:0]  elbow_y_o,
  output logic signed [17:0]  reach_x_o,
  output logic signed [17:0]  reach_y_o,
  output logic                out_of_reach_o
);
  import tlik_pkg::*;

  // Divide by 65536 with truncation toward zero.
  function automatic logic signed [39:0] trunc16(input logic signed [39:0] v);
    logic signed [39:0] b;
    b = v + (v[39] ? 40'sd65535 : 40'sd0);
    return b >>> 16;
  endfunction

  // Configuration registers.
  logic signed [15:0] ox_q, oy_q;
  logic [13:0]        l0_q, l1_q;
  logic               mirror_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q     <= '0;
      oy_q     <= '0;
      l0_q     <= 14'd100;
      l1_q     <= 14'd100;
      mirror_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ORIGIN_X:      ox_q     <= cfg_data_i;
        REG_ORIGIN_Y:      oy_q     <= cfg_data_i;
        REG_FIRST_LENGTH:  l0_q     <= cfg_data_i[13:0];
        REG_SECOND_LENGTH: l1_q     <= cfg_data_i[13:0];
        REG_MIRROR_ELBOW:  mirror_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Working registers.
  logic signed [16:0] dx_q, dy_q;
  logic signed [39:0] p_q, acc_q, num_q, den_q;
  logic [33:0]        sv_q, sr_q, rem_q;
  logic [16:0]        d_q, q_q;
  logic signed [35:0] cx_q, cy_q;
  logic signed [20:0] cz_q, zb_q;
  logic               neg_q, qneg_q, flag_q;
  logic signed [19:0] ct_q, st_q;
  logic signed [17:0] cq_q;
  logic signed [15:0] ex_q, ey_q;
  logic signed [16:0] elx_q, ely_q;
  logic signed [17:0] rx_q, ry_q;
  logic signed [16:0] elx_o_q, ely_o_q;
  logic signed [17:0] rx_o_q, ry_o_q;
  logic               flag_o_q;

  // Shared multiplier operand selection.
  logic signed [19:0] ma, mb;
  logic signed [39:0] prod;
  logic signed [19:0] l0_s, l1_s, d_s;

  assign l0_s = $signed({6'd0, l0_q});
  assign l1_s = $signed({6'd0, l1_q});
  assign d_s  = $signed({3'd0, d_q});

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_M1:   begin ma = 20'(dx_q); mb = 20'(dx_q); end
      OP_M2:   begin ma = 20'(dy_q); mb = 20'(dy_q); end
      OP_M3:   begin ma = l0_s; mb = l0_s; end
      OP_M4:   begin ma = d_s;  mb = d_s; end
      OP_M5:   begin ma = l1_s; mb = l1_s; end
      OP_M6:   begin ma = l0_s; mb = d_s; end
      OP_M7:   begin ma = 20'(cq_q); mb = 20'(cq_q); end
      OP_M8:   begin ma = l0_s; mb = $signed({3'd0, sr_q[16:0]}); end
      OP_M9:   begin ma = l0_s; mb = 20'(cq_q); end
      OP_M10:  begin ma = 20'(ex_q); mb = st_q; end
      OP_M11:  begin ma = 20'(ey_q); mb = ct_q; end
      OP_M12:  begin ma = 20'(ey_q); mb = st_q; end
      OP_M13:  begin ma = 20'(ex_q); mb = ct_q; end
      OP_M14:  begin ma = d_s; mb = ct_q; end
      OP_M15:  begin ma = d_s; mb = st_q; end
      default: ;
    endcase
  end

  assign prod = ma * mb;

  // Step helpers.
  logic [33:0]        sq_bit, sq_t, dv_t;
  logic signed [35:0] sx, sy, dx36, dy36;
  logic signed [20:0] atn, zt;
  logic signed [39:0] nnum, absn, sum_x, dif_y;

  assign sq_bit = 34'd1 << (6'd32 - {cmd_i.idx, 1'b0});
  assign sq_t   = sr_q + sq_bit;
  assign dv_t   = {rem_q[32:0], 1'b0};
  assign sx     = cx_q >>> cmd_i.idx;
  assign sy     = cy_q >>> cmd_i.idx;
  assign atn    = $signed({5'd0, atan_val(cmd_i.idx)});
  assign dx36   = 36'(dx_q);
  assign dy36   = 36'(dy_q);
  assign zt     = cz_q + zb_q;
  assign nnum   = -num_q;
  assign absn   = num_q[39] ? nnum : num_q;
  assign sum_x  = acc_q + p_q;
  assign dif_y  = acc_q - p_q;

  assign stat_o.d_zero   = (d_q == '0);
  assign stat_o.need_div = (den_q != '0) && (num_q < den_q) && (nnum < den_q);

  // Operation execution.
  always_ff @(posedge clk_i) begin
    p_q <= prod;
    case (cmd_i.op)
      OP_LOAD: begin
        dx_q   <= 17'(goal_x_i) - 17'(ox_q);
        dy_q   <= 17'(goal_y_i) - 17'(oy_q);
        flag_q <= 1'b0;
      end
      OP_M2:  acc_q <= p_q;
      OP_SQ0: begin
        sv_q <= sum_x[33:0];
        sr_q <= '0;
      end
      OP_SQST: begin
        if (sv_q >= sq_t) begin
          sv_q <= sv_q - sq_t;
          sr_q <= (sr_q >> 1) + sq_bit;
        end else begin
          sr_q <= sr_q >> 1;
        end
      end
      OP_DSET: d_q <= sr_q[16:0];
      OP_ZERO: begin
        ct_q   <= '0;
        st_q   <= 20'sd65536;
        flag_q <= 1'b1;
      end
      OP_VINIT: begin
        cz_q <= '0;
        if (dx_q[16]) begin
          cx_q <= (-dx36) <<< 16;
          cy_q <= (-dy36) <<< 16;
          zb_q <= dy_q[16] ? -ANG_PI : ANG_PI;
        end else begin
          cx_q <= dx36 <<< 16;
          cy_q <= dy36 <<< 16;
          zb_q <= '0;
        end
      end
      OP_VSTEP: begin
        if (!cy_q[35]) begin
          cx_q <= cx_q + sy;
          cy_q <= cy_q - sx;
          cz_q <= cz_q + atn;
        end else begin
          cx_q <= cx_q - sy;
          cy_q <= cy_q + sx;
          cz_q <= cz_q - atn;
        end
      end
      OP_RINIT: begin
        cx_q <= CORDIC_INV_GAIN;
        cy_q <= '0;
        if (zt > ANG_HALF_PI) begin
          cz_q  <= zt - ANG_PI;
          neg_q <= 1'b1;
        end else if (zt < -ANG_HALF_PI) begin
          cz_q  <= zt + ANG_PI;
          neg_q <= 1'b1;
        end else begin
          cz_q  <= zt;
          neg_q <= 1'b0;
        end
      end
      OP_RSTEP: begin
        if (!cz_q[20]) begin
          cx_q <= cx_q - sy;
          cy_q <= cy_q + sx;
          cz_q <= cz_q - atn;
        end else begin
          cx_q <= cx_q + sy;
          cy_q <= cy_q - sx;
          cz_q <= cz_q + atn;
        end
      end
      OP_RFIN: begin
        ct_q <= neg_q ? -cx_q[19:0] : cx_q[19:0];
        st_q <= neg_q ? -cy_q[19:0] : cy_q[19:0];
      end
      OP_M4:  acc_q <= p_q;
      OP_M5:  acc_q <= acc_q + p_q;
      OP_M6:  num_q <= acc_q - p_q;
      OP_DEN: den_q <= p_q <<< 1;
      OP_CHK: begin
        // Clamp the cosine, or set up the restoring divider.
        rem_q  <= absn[33:0];
        q_q    <= '0;
        qneg_q <= num_q[39];
        if (den_q == '0) begin
          cq_q   <= 18'sd65536;
          flag_q <= 1'b1;
        end else if (num_q >= den_q) begin
          cq_q <= 18'sd65536;
          if (num_q > den_q) flag_q <= 1'b1;
        end else if (nnum >= den_q) begin
          cq_q <= -18'sd65536;
          if (nnum > den_q) flag_q <= 1'b1;
        end
      end
      OP_DSTEP: begin
        if (dv_t >= den_q[33:0]) begin
          rem_q <= dv_t - den_q[33:0];
          q_q   <= {q_q[15:0], 1'b1};
        end else begin
          rem_q <= dv_t;
          q_q   <= {q_q[15:0], 1'b0};
        end
      end
      OP_DFIN: cq_q <= qneg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
      OP_SQ1: begin
        sv_q <= 34'h1_0000_0000 - p_q[33:0];
        sr_q <= '0;
      end
      OP_M9:  ex_q <= mirror_q ? $signed(p_q[31:16]) : -$signed(p_q[31:16]);
      OP_M10: ey_q <= 16'(trunc16(p_q));
      OP_M11: acc_q <= p_q;
      OP_M12: elx_q <= 17'(ox_q) + 17'(trunc16(sum_x));
      OP_M13: acc_q <= p_q;
      OP_M14: ely_q <= 17'(oy_q) + 17'(trunc16(dif_y));
      OP_M15: rx_q <= 18'(ox_q) + 18'(trunc16(p_q));
      OP_M16: ry_q <= 18'(oy_q) + 18'(trunc16(p_q));
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      elx_o_q  <= elx_q;
      ely_o_q  <= ely_q;
      rx_o_q   <= rx_q;
      ry_o_q   <= ry_q;
      flag_o_q <= flag_q;
    end
  end

  assign elbow_x_o      = elx_o_q;
  assign elbow_y_o      = ely_o_q;
  assign reach_x_o      = rx_o_q;
  assign reach_y_o      = ry_o_q;
  assign out_of_reach_o = flag_o_q;

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the two-link inverse kinematics unit. A short
// table of directed targets runs first, then random phases under several
// shoulder, link length and mirror settings. Every accepted item is solved
// by a fixed-point arm solver inside the testbench, and each result is
// compared field by field with the oldest pending solution.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlik_pkg::*;

  localparam int  RANDOM_ITEMS = 1950;
  localparam int  PHASES       = 10;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint Q16       = 65536;

  typedef struct packed {
    logic [16:0] elbow_x;
    logic [16:0] elbow_y;
    logic [17:0] reach_x;
    logic [17:0] reach_y;
    logic        out_of_reach;
  } arm_sol_t;

  typedef struct {
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    bit                 typed;
    arm_sol_t           sol;
  } target_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = REG_ORIGIN_X;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] goal_x_i = '0;
  logic signed [15:0] goal_y_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [16:0] elbow_x_o;
  logic signed [16:0] elbow_y_o;
  logic signed [17:0] reach_x_o;
  logic signed [17:0] reach_y_o;
  logic               out_of_reach_o;

  // Register copies used by the solver.
  logic signed [15:0] arm_org_x;
  logic signed [15:0] arm_org_y;
  logic [13:0]        arm_len0;
  logic [13:0]        arm_len1;
  logic               arm_mirror;

  arm_sol_t    pending_sols[$];
  target_row_t typed_rows[$];
  int          errors = 0;
  int          items_sent = 0;
  int          sols_seen = 0;
  int          flagged_seen = 0;
  int          ready_hold = 0;
  bit          steady_mode = 1'b0;
  longint      cycles = 0;

  two_link_inverse_kinematics_unit i_dut (.*);

  // Clock: 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Fixed-point arm solver.
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int atan_step(int i);
    int steps[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                      256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 17) ? steps[i] : 0;
  endfunction

  function automatic longint goal_angle(longint y, longint x);
    longint z, base, nx, ny;
    z = 0;
    base = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      base = (y <= 0) ? longint'(ANG_PI) : -longint'(ANG_PI);
    end
    x = x * Q16;
    y = y * Q16;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += longint'(atan_step(i));
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= longint'(atan_step(i));
      end
      x = nx;
      y = ny;
    end
    return z + base;
  endfunction

  function automatic void angle_trig(longint z, output longint c, output longint s);
    longint x, y, nx, ny;
    bit flip;
    x = longint'(CORDIC_INV_GAIN);
    y = 0;
    flip = 1'b0;
    if (z > longint'(ANG_HALF_PI)) begin
      z -= longint'(ANG_PI);
      flip = 1'b1;
    end else if (z < -longint'(ANG_HALF_PI)) begin
      z += longint'(ANG_PI);
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= longint'(atan_step(i));
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += longint'(atan_step(i));
      end
      x = nx;
      y = ny;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic arm_sol_t solve_arm(logic signed [15:0] gx, logic signed [15:0] gy);
    longint ox, oy, l0, l1, dx, dy, d, ct, st, num, den, cq, sq, ex, ey;
    arm_sol_t r;
    ox = arm_org_x;
    oy = arm_org_y;
    l0 = arm_len0;
    l1 = arm_len1;
    dx = longint'(gx) - ox;
    dy = longint'(gy) - oy;
    r.out_of_reach = 1'b0;
    d = longint'(int_root(dx * dx + dy * dy));
    // A zero distance points the arm straight up.
    if (d == 0) begin
      ct = 0;
      st = Q16;
      r.out_of_reach = 1'b1;
    end else begin
      angle_trig(goal_angle(dy, dx), ct, st);
    end
    // Law of cosines with the cosine clamped to plus or minus one.
    num = l0 * l0 + d * d - l1 * l1;
    den = 2 * l0 * d;
    if (den == 0) begin
      cq = Q16;
      r.out_of_reach = 1'b1;
    end else if (num >= den) begin
      cq = Q16;
      if (num > den) r.out_of_reach = 1'b1;
    end else if (-num >= den) begin
      cq = -Q16;
      if (-num > den) r.out_of_reach = 1'b1;
    end else begin
      cq = num * Q16 / den;
    end
    sq = longint'(int_root((64'd1 << 32) - longint'(cq * cq)));
    ey = l0 * cq / Q16;
    ex = -(l0 * sq / Q16);
    if (arm_mirror) ex = -ex;
    r.elbow_x = 17'(ox + (ex * st + ey * ct) / Q16);
    r.elbow_y = 17'(oy + (ey * st - ex * ct) / Q16);
    r.reach_x = 18'(ox + d * ct / Q16);
    r.reach_y = 18'(oy + d * st / Q16);
    return r;
  endfunction

  // Register write while the unit is idle; the solver copy follows.
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_ORIGIN_X:      arm_org_x = data;
      REG_ORIGIN_Y:      arm_org_y = data;
      REG_FIRST_LENGTH:  arm_len0 = data[13:0];
      REG_SECOND_LENGTH: arm_len1 = data[13:0];
      REG_MIRROR_ELBOW:  arm_mirror = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_arm(logic [15:0] ox, logic [15:0] oy, logic [15:0] l0,
                           logic [15:0] l1, logic [15:0] mir);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_FIRST_LENGTH, l0);
    write_reg(REG_SECOND_LENGTH, l1);
    write_reg(REG_MIRROR_ELBOW, mir);
  endtask

  // Offer one target item and hold it until accepted.
  task automatic send_goal(logic signed [15:0] gx, logic signed [15:0] gy);
    int gap;
    gap = steady_mode ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    goal_x_i <= gx;
    goal_y_i <= gy;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Wait until every pending solution has come back, then let the unit settle.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_sols.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Receiver stall: a fresh hold count after every accepted result.
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      out_ready_i <= 1'b0;
      ready_hold--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Record accepted targets and check accepted results.
  always @(posedge clk_i) begin
    arm_sol_t want;
    arm_sol_t got;
    cycles++;
    if (rst_ni && in_valid_i && in_ready_o) pending_sols.push_back(solve_arm(goal_x_i, goal_y_i));
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{elbow_x_o, elbow_y_o, reach_x_o, reach_y_o, out_of_reach_o};
      sols_seen++;
      flagged_seen += out_of_reach_o;
      ready_hold = steady_mode ? 0 : $urandom_range(0, 8);
      if (pending_sols.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $realtime, got);
        errors++;
      end else begin
        want = pending_sols.pop_front();
        if (got.elbow_x !== want.elbow_x)
          $display("%0t: elbow_x expected %0d actual %0d", $realtime,
                   $signed(want.elbow_x), $signed(got.elbow_x));
        if (got.elbow_y !== want.elbow_y)
          $display("%0t: elbow_y expected %0d actual %0d", $realtime,
                   $signed(want.elbow_y), $signed(got.elbow_y));
        if (got.reach_x !== want.reach_x)
          $display("%0t: reach_x expected %0d actual %0d", $realtime,
                   $signed(want.reach_x), $signed(got.reach_x));
        if (got.reach_y !== want.reach_y)
          $display("%0t: reach_y expected %0d actual %0d", $realtime,
                   $signed(want.reach_y), $signed(got.reach_y));
        if (got.out_of_reach !== want.out_of_reach)
          $display("%0t: out_of_reach expected %0b actual %0b", $realtime,
                   want.out_of_reach, got.out_of_reach);
        if (got !== want) errors++;
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $realtime, pending_sols.size());
      $display("two_link_inverse_kinematics_unit: mismatch");
      $finish;
    end
  end

  // Stimulus and final verdict.
  initial begin
    target_row_t row;
    int reach, pick, per_phase;
    logic signed [15:0] gx, gy;

    arm_org_x = 16'sd0;
    arm_org_y = 16'sd0;
    arm_len0 = 14'd100;
    arm_len1 = 14'd100;
    arm_mirror = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed targets at the reset settings. The zero-distance row is typed
    // in: straight-up elbow, reach at the shoulder, flag set.
    typed_rows = '{
      '{16'sd0, 16'sd0, 1'b1, '{17'sd0, 17'sd100, 18'sd0, 18'sd0, 1'b1}},
      '{16'sd200, 16'sd0, 1'b0, '0},
      '{16'sd0, 16'sd200, 1'b0, '0},
      '{-16'sd200, 16'sd0, 1'b0, '0},
      '{16'sd0, -16'sd200, 1'b0, '0},
      '{-16'sd150, -16'sd1, 1'b0, '0},
      '{-16'sd150, 16'sd1, 1'b0, '0},
      '{16'sd100, 16'sd100, 1'b0, '0},
      '{16'sd1, 16'sd0, 1'b0, '0},
      '{16'sd0, 16'sd1, 1'b0, '0},
      '{16'sd201, 16'sd0, 1'b0, '0},
      '{16'sd32767, 16'sd32767, 1'b0, '0},
      '{-16'sd32768, -16'sd32768, 1'b0, '0},
      '{16'sd32767, -16'sd32768, 1'b0, '0},
      '{-16'sd32768, 16'sd32767, 1'b0, '0},
      '{-16'sd32768, 16'sd0, 1'b0, '0},
      '{16'sd0, -16'sd32768, 1'b0, '0},
      '{-16'sd1, -16'sd1, 1'b0, '0},
      '{16'sd50, -16'sd30, 1'b0, '0}
    };
    foreach (typed_rows[k]) begin
      row = typed_rows[k];
      if (row.typed && solve_arm(row.gx, row.gy) !== row.sol) begin
        $display("%0t: directed row %0d expected %p solver %p", $realtime, k,
                 row.sol, solve_arm(row.gx, row.gy));
        errors++;
      end
      send_goal(row.gx, row.gy);
    end
    wait_drained();

    // Random phases: fixed extremes first, then random settings.
    per_phase = RANDOM_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_arm(16'h7FFF, 16'h8000, 16'd16383, 16'd1, 16'd1);
        1: write_arm(16'h8000, 16'h7FFF, 16'd1, 16'd16383, 16'd0);
        2: write_arm(16'd0, 16'd0, 16'h4000, 16'd50, 16'hFFFE);
        3: write_arm(16'd0, 16'd0, 16'd16383, 16'd16383, 16'd1);
        default: begin
          pick = $urandom_range(0, 3);
          write_arm(16'($urandom()), 16'($urandom()),
                    (pick == 0) ? 16'($urandom()) : 16'($urandom_range(1, 400)),
                    (pick == 1) ? 16'($urandom()) : 16'($urandom_range(1, 400)),
                    16'($urandom()));
        end
      endcase
      steady_mode = (p == 5);
      reach = int'(arm_len0) + int'(arm_len1) + 8;
      for (int n = 0; n < per_phase; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          gx = 16'($urandom());
          gy = 16'($urandom());
        end else if (pick < 90) begin
          // Near the shoulder, mostly within or just past the arm's reach.
          gx = 16'(int'(arm_org_x) + $signed($urandom_range(0, 2 * reach)) - reach);
          gy = 16'(int'(arm_org_y) + $signed($urandom_range(0, 2 * reach)) - reach);
          if (pick < 48) gx = arm_org_x;
          else if (pick < 52) gy = arm_org_y;
        end else begin
          gx = arm_org_x;
          gy = arm_org_y;
        end
        send_goal(gx, gy);
        if (n == per_phase / 2 && p == 7) wait_drained();
      end
      wait_drained();
    end

    repeat (200) @(posedge clk_i);
    $display("Ran %0d targets over %0d arm settings; %0d results checked, %0d flagged.",
             items_sent, PHASES + 1, sols_seen, flagged_seen);
    if (errors == 0 && pending_sols.size() == 0) begin
      $display("two_link_inverse_kinematics_unit: match");
    end else begin
      $display("two_link_inverse_kinematics_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tlik_pkg.sv
rtl/tlik_ctrl.sv
rtl/tlik_dp.sv
rtl/two_link_inverse_kinematics_unit.sv
test/tb.sv
